@@ src/fsig_pkg.sv @@
// fsig_pkg: shared types and constants for the file signature matcher
// no dependencies; imported by file_signature_matcher
`default_nettype none

package fsig_pkg;

    // table size, fixed by the 4-bit entry and match_index fields
    localparam int ENTRIES       = 16;
    localparam int ENT_W         = 4;
    // default pattern sizes
    localparam int HDR_BYTES_DEF = 32;
    localparam int FTR_BYTES_DEF = 16;
    // shortest header stream that may match
    localparam int MIN_STREAM    = 4;

    typedef enum logic [1:0] {
        REQ_WR_PATTERN = 2'd0,
        REQ_WR_LENGTHS = 2'd1,
        REQ_HDR_BYTE   = 2'd2,
        REQ_FTR_BYTE   = 2'd3
    } req_t;

    typedef enum logic {
        PAT_HEADER = 1'b0,
        PAT_FOOTER = 1'b1
    } pat_sel_t;

    typedef enum logic {
        RES_HEADER = 1'b0,
        RES_FOOTER = 1'b1
    } res_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } fsm_state_t;

endpackage

`default_nettype wire

@@ src/file_signature_matcher.sv @@
// file_signature_matcher: header/footer signature table with stream matching
// depends on fsig_pkg (types, request codes, sizes)
`default_nettype none

// Usage
//   s_ channel: one beat per request. pattern-byte and length writes load the
//   table; header stream beats (closed by s_last) match the start of a data
//   stream against all entries; footer stream beats (closed by s_last) check
//   the tail against the footer of the entry named on the closing beat.
//   m_ channel: one result beat per closing stream beat, none otherwise.
//   cfg_we/cfg_wdata: entry_count; user writes it only while idle, unchecked.
// Beat handling
//   a table write needs no compare cycle. a stream beat has an accept cycle that
//   issues the read of the pattern memory (header memory row at the current
//   byte offset, or the footer memory row of the entry), then a compare cycle
//   that checks all entries against the registered row. no new beat is taken
//   during the compare cycle; m_valid rises after the closing beat's compare,
//   later only while an earlier result still waits in the result register.
// Reset and stall
//   reset clears lengths, stream state, entry_count and the result valid flag;
//   pattern memories are not cleared and need no clearing pass.
//   a waiting result does not block new beats; only a closing beat that finds
//   the result register still full waits in its compare cycle.
module file_signature_matcher #(
    parameter int HDR_BYTES = fsig_pkg::HDR_BYTES_DEF,
    parameter int FTR_BYTES = fsig_pkg::FTR_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    // request channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [3:0] s_entry,
    input  wire logic       s_which_pattern,
    input  wire logic [4:0] s_position,
    input  wire logic [7:0] s_byte_value,
    input  wire logic [5:0] s_header_length,
    input  wire logic [4:0] s_footer_length,
    input  wire logic       s_last,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_result_kind,
    output logic            m_found,
    output logic [3:0]      m_match_index,
    output logic            m_footer_ok
);
    import fsig_pkg::*;

    // derived widths
    localparam int HL_W   = $clog2(HDR_BYTES + 1);   // header length / byte count
    localparam int HA_W   = $clog2(HDR_BYTES);       // header memory row address
    localparam int FL_W   = $clog2(FTR_BYTES + 1);   // footer length / fill count
    localparam int FA_W   = (FTR_BYTES > 1) ? $clog2(FTR_BYTES) : 1;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    fsm_state_t state_reg, state_next;

    logic [4:0]      entry_count_reg;
    logic [HL_W-1:0] hlen_reg [ENTRIES];
    logic [FL_W-1:0] flen_reg [ENTRIES];

    logic [ENTRIES-1:0] still_reg;      // entries still matching the header stream
    logic [HL_W-1:0]    seen_reg;       // header bytes seen, saturates at HDR_BYTES
    logic [FTR_BYTES-1:0][7:0] tail_reg; // newest byte at the top
    logic [FL_W-1:0]    fill_reg;       // footer bytes seen, saturates

    // beat held for the compare cycle
    req_t            req_reg;
    logic [ENT_W-1:0] ent_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;

    // pattern memories: header rows by byte offset, footer rows by entry
    logic [ENTRIES-1:0][7:0]   hdr_mem [HDR_BYTES];
    logic [FTR_BYTES-1:0][7:0] ftr_mem [ENTRIES];
    logic [ENTRIES-1:0][7:0]   hdr_row_reg;
    logic [FTR_BYTES-1:0][7:0] ftr_row_reg;

    // result register
    logic            m_valid_reg;
    res_kind_t       m_kind_reg;
    logic            m_found_reg;
    logic [ENT_W-1:0] m_index_reg;
    logic            m_ok_reg;

    // ---------------------------------------------------------------
    // handshake and control
    // ---------------------------------------------------------------
    logic s_acc;
    logic out_free;
    logic advance;
    logic is_stream;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_stream = (s_req_type == REQ_HDR_BYTE) || (s_req_type == REQ_FTR_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        advance    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && is_stream) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // a closing beat waits for room in the result register
                if (!last_reg || out_free) begin
                    advance    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // write-side decode
    // ---------------------------------------------------------------
    logic [HL_W-1:0] hlen_sat;
    logic [FL_W-1:0] flen_sat;
    logic [HA_W-1:0] hdr_waddr;
    logic [FA_W-1:0] ftr_lane;
    logic            hdr_pos_ok;
    logic            ftr_pos_ok;
    logic            seen_open;

    assign hlen_sat   = (32'(s_header_length) > HDR_BYTES) ? HL_W'(HDR_BYTES)
                                                           : HL_W'(32'(s_header_length));
    assign flen_sat   = (32'(s_footer_length) > FTR_BYTES) ? FL_W'(FTR_BYTES)
                                                           : FL_W'(32'(s_footer_length));
    assign hdr_waddr  = HA_W'(32'(s_position));
    assign ftr_lane   = FA_W'(32'(s_position));
    assign hdr_pos_ok = 32'(s_position) < HDR_BYTES;
    assign ftr_pos_ok = 32'(s_position) < FTR_BYTES;
    assign seen_open  = 32'(seen_reg) < HDR_BYTES;

    // memories: byte-lane writes, registered row reads
    always_ff @(posedge aclk) begin
        if (s_acc && (s_req_type == REQ_WR_PATTERN)) begin
            if ((s_which_pattern == PAT_HEADER) && hdr_pos_ok) begin
                hdr_mem[hdr_waddr][s_entry] <= s_byte_value;
            end
            if ((s_which_pattern == PAT_FOOTER) && ftr_pos_ok) begin
                ftr_mem[s_entry][ftr_lane] <= s_byte_value;
            end
        end
        if (s_acc && (s_req_type == REQ_HDR_BYTE) && seen_open) begin
            hdr_row_reg <= hdr_mem[seen_reg[HA_W-1:0]];
        end
        if (s_acc && (s_req_type == REQ_FTR_BYTE)) begin
            ftr_row_reg <= ftr_mem[s_entry];
        end
    end

    // beat capture for the compare cycle
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_reg  <= req_t'(s_req_type);
            ent_reg  <= s_entry;
            byte_reg <= s_byte_value;
            last_reg <= s_last;
        end
    end

    // ---------------------------------------------------------------
    // header compare: all entries in parallel against the row
    // ---------------------------------------------------------------
    logic [ENTRIES-1:0] keep;
    logic [HL_W-1:0]    len_next;
    logic               hdr_found;
    logic [ENT_W-1:0]   hdr_index;

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            keep[e] = still_reg[e];
            if (seen_open && (seen_reg < hlen_reg[e]) && (hdr_row_reg[e] != byte_reg)) begin
                keep[e] = 1'b0;
            end
        end
        len_next = seen_open ? seen_reg + HL_W'(1) : seen_reg;

        // lowest entry in use wins, so scan from the top down
        hdr_found = 1'b0;
        hdr_index = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if ((32'(len_next) >= MIN_STREAM) && (32'(e) < 32'(entry_count_reg)) &&
                (hlen_reg[e] != '0) && (hlen_reg[e] <= len_next) && keep[e]) begin
                hdr_found = 1'b1;
                hdr_index = ENT_W'(e);
            end
        end
    end

    // ---------------------------------------------------------------
    // footer compare: align the tail window to the footer length
    // ---------------------------------------------------------------
    logic [FL_W-1:0]           fl;
    logic [FTR_BYTES-1:0][7:0] tail_aligned;
    logic                      ftr_miss;
    logic                      ftr_ok;

    assign fl           = flen_reg[ent_reg];
    assign tail_aligned = tail_reg >> (8 * (FTR_BYTES - 32'(fl)));

    always_comb begin
        ftr_miss = 1'b0;
        for (int k = 0; k < FTR_BYTES; k++) begin
            if ((32'(k) < 32'(fl)) && (tail_aligned[k] != ftr_row_reg[k])) begin
                ftr_miss = 1'b1;
            end
        end
        ftr_ok = (32'(ent_reg) < 32'(entry_count_reg)) && (fl != '0) &&
                 (fl <= fill_reg) && !ftr_miss;
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            still_reg       <= '1;
            seen_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                hlen_reg[e] <= '0;
                flen_reg[e] <= '0;
            end
        end else begin
            if (cfg_we) begin
                entry_count_reg <= cfg_wdata;
            end

            if (s_acc && (s_req_type == REQ_WR_LENGTHS)) begin
                hlen_reg[s_entry] <= hlen_sat;
                flen_reg[s_entry] <= flen_sat;
            end

            // footer window shifts on accept
            if (s_acc && (s_req_type == REQ_FTR_BYTE)) begin
                for (int k = 0; k < FTR_BYTES - 1; k++) begin
                    tail_reg[k] <= tail_reg[k + 1];
                end
                tail_reg[FTR_BYTES - 1] <= s_byte_value;
                if (32'(fill_reg) < FTR_BYTES) begin
                    fill_reg <= fill_reg + FL_W'(1);
                end
            end

            // a new result takes the register in the cycle the old one leaves
            if (advance && last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (req_reg == REQ_HDR_BYTE) begin
                    still_reg <= last_reg ? '1 : keep;
                    seen_reg  <= last_reg ? '0 : len_next;
                end else if (last_reg) begin
                    tail_reg <= '0;
                    fill_reg <= '0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            if (req_reg == REQ_HDR_BYTE) begin
                m_kind_reg  <= RES_HEADER;
                m_found_reg <= hdr_found;
                m_index_reg <= hdr_index;
                m_ok_reg    <= 1'b0;
            end else begin
                m_kind_reg  <= RES_FOOTER;
                m_found_reg <= 1'b0;
                m_index_reg <= '0;
                m_ok_reg    <= ftr_ok;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_found       = m_found_reg;
    assign m_match_index = m_index_reg;
    assign m_footer_ok   = m_ok_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_stream_goes_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_stream |=> state_reg == ST_EVAL)
        else $error("stream beat did not enter compare cycle");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(seen_reg) <= HDR_BYTES)
        else $error("header byte count past limit");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= FTR_BYTES)
        else $error("footer fill count past limit");

    a_result_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EVAL) && $past(last_reg))
        else $error("result without closing compare");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_reg |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

@@ sim/tb_file_signature_matcher.sv @@
// tb_file_signature_matcher: self-checking testbench for file_signature_matcher
// depends on fsig_pkg and the matcher RTL; loads the signature table, runs header
// and footer streams, predicts each result beat and checks it in arrival order
module tb_file_signature_matcher;
    import fsig_pkg::*;

    localparam int     HDR_N      = HDR_BYTES_DEF;
    localparam int     FTR_N      = FTR_BYTES_DEF;
    localparam int     LONG_HOLD  = 300;     // receiver hold-off in the pressure phase
    localparam int     SETTLE     = 8;
    localparam longint LIMIT_TIME = 64'd6_000_000;

    // one request beat as queued for the driver
    typedef struct {
        req_t       req;
        logic [3:0] entry;
        pat_sel_t   which;
        logic [4:0] position;
        logic [7:0] value;
        logic [5:0] hlen;
        logic [4:0] flen;
        logic       last;
        bit         drain_first;   // hold this beat back until no result is owed
    } req_beat_t;

    typedef struct packed {
        res_kind_t  kind;
        logic       found;
        logic [3:0] idx;
        logic       footer_ok;
    } sig_result_t;

    // dut signals, all inputs known from time zero
    logic       aclk;
    logic       aresetn         = 1'b0;
    logic       cfg_we          = 1'b0;
    logic [4:0] cfg_wdata       = '0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_req_type      = '0;
    logic [3:0] s_entry         = '0;
    logic       s_which_pattern = 1'b0;
    logic [4:0] s_position      = '0;
    logic [7:0] s_byte_value    = '0;
    logic [5:0] s_header_length = '0;
    logic [4:0] s_footer_length = '0;
    logic       s_last          = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_result_kind;
    logic       m_found;
    logic [3:0] m_match_index;
    logic       m_footer_ok;

    file_signature_matcher u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_entry        (s_entry),
        .s_which_pattern(s_which_pattern),
        .s_position     (s_position),
        .s_byte_value   (s_byte_value),
        .s_header_length(s_header_length),
        .s_footer_length(s_footer_length),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_found        (m_found),
        .m_match_index  (m_match_index),
        .m_footer_ok    (m_footer_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // signature table predictor: its own copy of table, stream state and count
    // ------------------------------------------------------------------
    bit [7:0]    sig_hdr_pat [ENTRIES][HDR_N];
    bit [7:0]    sig_ftr_pat [ENTRIES][FTR_N];
    int          sig_hdr_len [ENTRIES];
    int          sig_ftr_len [ENTRIES];
    bit          sig_alive   [ENTRIES];      // entries still matching the header stream
    int          sig_seen;                   // header bytes compared, saturates at HDR_N
    bit [7:0]    sig_tail    [FTR_N];        // newest footer stream bytes, oldest first
    int          sig_tail_fill;
    int          sig_entry_count;
    sig_result_t expected_results[$];

    function automatic void predict_signature_beat(input req_beat_t b);
        int          n;
        int          fl;
        bit          hit;
        sig_result_t r;
        n = (sig_entry_count > ENTRIES) ? ENTRIES : sig_entry_count;
        case (b.req)
            REQ_WR_PATTERN: begin
                if (b.which == PAT_HEADER)
                    sig_hdr_pat[b.entry][b.position] = b.value;
                else if (b.position < FTR_N)
                    sig_ftr_pat[b.entry][b.position] = b.value;
            end
            REQ_WR_LENGTHS: begin
                sig_hdr_len[b.entry] = (b.hlen > HDR_N) ? HDR_N : int'(b.hlen);
                sig_ftr_len[b.entry] = (b.flen > FTR_N) ? FTR_N : int'(b.flen);
            end
            REQ_HDR_BYTE: begin
                if (sig_seen < HDR_N) begin
                    for (int e = 0; e < ENTRIES; e++)
                        if (sig_seen < sig_hdr_len[e] && sig_hdr_pat[e][sig_seen] != b.value)
                            sig_alive[e] = 1'b0;
                    sig_seen++;
                end
                if (b.last) begin
                    r = '{RES_HEADER, 1'b0, 4'd0, 1'b0};
                    // scan from the top so the lowest matching entry is the one kept
                    if (sig_seen >= MIN_STREAM)
                        for (int e = n - 1; e >= 0; e--)
                            if (sig_hdr_len[e] != 0 && sig_hdr_len[e] <= sig_seen && sig_alive[e])
                            begin
                                r.found = 1'b1;
                                r.idx   = 4'(e);
                            end
                    expected_results.push_back(r);
                    foreach (sig_alive[e]) sig_alive[e] = 1'b1;
                    sig_seen = 0;
                end
            end
            default: begin
                for (int k = 0; k < FTR_N - 1; k++) sig_tail[k] = sig_tail[k + 1];
                sig_tail[FTR_N - 1] = b.value;
                if (sig_tail_fill < FTR_N) sig_tail_fill++;
                if (b.last) begin
                    r  = '{RES_FOOTER, 1'b0, 4'd0, 1'b0};
                    fl = sig_ftr_len[b.entry];
                    if (b.entry < n && fl != 0 && fl <= sig_tail_fill) begin
                        hit = 1'b1;
                        for (int k = 0; k < fl; k++)
                            if (sig_tail[FTR_N - fl + k] != sig_ftr_pat[b.entry][k]) hit = 1'b0;
                        r.footer_ok = hit;
                    end
                    expected_results.push_back(r);
                    foreach (sig_tail[k]) sig_tail[k] = 8'h00;
                    sig_tail_fill = 0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // beat generation; keeps its own view of the table so streams can be built
    // to match, and writes every pattern byte before a length can cover it
    // ------------------------------------------------------------------
    req_beat_t  pending_beats[$];
    bit [7:0]   gen_hdr     [ENTRIES][HDR_N];
    bit [7:0]   gen_ftr     [ENTRIES][FTR_N];
    bit         gen_hdr_set [ENTRIES][HDR_N];
    bit         gen_ftr_set [ENTRIES][FTR_N];
    int         gen_hlen    [ENTRIES];
    int         gen_flen    [ENTRIES];
    int         gen_count;          // entry_count in force for the beats being built
    int         gen_pushed;
    bit         gen_drain_next;
    logic [7:0] hdr_bytes[$];
    logic [7:0] ftr_bytes[$];

    // every field random; callers pin the ones that matter
    function automatic req_beat_t random_beat(input req_t kind);
        req_beat_t b;
        b.req         = kind;
        b.entry       = 4'($urandom_range(15));
        b.which       = pat_sel_t'($urandom_range(1));
        b.position    = 5'($urandom_range(31));
        b.value       = 8'($urandom_range(255));
        b.hlen        = 6'($urandom_range(63));
        b.flen        = 5'($urandom_range(31));
        b.last        = 1'($urandom_range(1));
        b.drain_first = 1'b0;
        return b;
    endfunction

    function automatic void queue_beat(input req_beat_t b);
        b.drain_first  = gen_drain_next;
        gen_drain_next = 1'b0;
        pending_beats.push_back(b);
        gen_pushed++;
    endfunction

    function automatic void load_byte(input int e, input pat_sel_t which, input int pos,
                                      input logic [7:0] val);
        req_beat_t b;
        b          = random_beat(REQ_WR_PATTERN);
        b.entry    = 4'(e);
        b.which    = which;
        b.position = 5'(pos);
        b.value    = val;
        queue_beat(b);
        if (which == PAT_HEADER) begin
            gen_hdr[e][pos]     = val;
            gen_hdr_set[e][pos] = 1'b1;
        end else if (pos < FTR_N) begin
            gen_ftr[e][pos]     = val;
            gen_ftr_set[e][pos] = 1'b1;
        end
    endfunction

    function automatic int pick_hlen();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 0;
        if (r < 70) return $urandom_range(6, 1);
        if (r < 88) return $urandom_range(32, 7);
        return $urandom_range(63, 33);             // saturates at the header size
    endfunction

    function automatic int pick_flen();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 70) return $urandom_range(4, 1);
        if (r < 90) return $urandom_range(16, 5);
        return $urandom_range(31, 17);             // saturates at the footer size
    endfunction

    function automatic void load_lengths(input int e, input int hl, input int fl);
        req_beat_t b;
        // fill any byte the new lengths would expose before it was written
        for (int p = 0; p < hl && p < HDR_N; p++)
            if (!gen_hdr_set[e][p]) load_byte(e, PAT_HEADER, p, 8'($urandom_range(255)));
        for (int p = 0; p < fl && p < FTR_N; p++)
            if (!gen_ftr_set[e][p]) load_byte(e, PAT_FOOTER, p, 8'($urandom_range(255)));
        b       = random_beat(REQ_WR_LENGTHS);
        b.entry = 4'(e);
        b.hlen  = 6'(hl);
        b.flen  = 5'(fl);
        queue_beat(b);
        gen_hlen[e] = (hl > HDR_N) ? HDR_N : hl;
        gen_flen[e] = (fl > FTR_N) ? FTR_N : fl;
    endfunction

    // full entry load; often copies another entry's header so several entries compete
    function automatic void load_entry(input int e);
        int hl;
        int fl;
        int src;
        bit share;
        hl    = pick_hlen();
        fl    = pick_flen();
        src   = $urandom_range(ENTRIES - 1);
        share = ($urandom_range(99) < 60);
        for (int p = 0; p < hl && p < HDR_N; p++)
            load_byte(e, PAT_HEADER, p,
                      (share && gen_hdr_set[src][p]) ? gen_hdr[src][p] : 8'($urandom_range(255)));
        for (int p = 0; p < fl && p < FTR_N; p++)
            load_byte(e, PAT_FOOTER, p, 8'($urandom_range(255)));
        load_lengths(e, hl, fl);
    endfunction

    function automatic void random_write();
        if ($urandom_range(3) != 0)
            load_byte($urandom_range(15), pat_sel_t'($urandom_range(1)), $urandom_range(31),
                      8'($urandom_range(255)));
        else
            load_lengths($urandom_range(15), pick_hlen(), pick_flen());
    endfunction

    function automatic int pick_entry();
        if (gen_count > 0 && $urandom_range(99) < 85)
            return $urandom_range(((gen_count > ENTRIES) ? ENTRIES : gen_count) - 1);
        return $urandom_range(ENTRIES - 1);
    endfunction

    // kind 0: an entry's header plus tail, kind 1: under four bytes, else random
    function automatic void build_header(input int kind);
        int e;
        int total;
        int at;
        hdr_bytes.delete();
        e = pick_entry();
        case (kind)
            0: begin
                for (int p = 0; p < gen_hlen[e]; p++) hdr_bytes.push_back(gen_hdr[e][p]);
                total = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                                 : hdr_bytes.size() + $urandom_range(3);
                while (hdr_bytes.size() > total) void'(hdr_bytes.pop_back());
            end
            1: begin
                total = $urandom_range(3, 1);
                for (int p = 0; p < total; p++)
                    hdr_bytes.push_back(gen_hdr_set[e][p] ? gen_hdr[e][p]
                                                          : 8'($urandom_range(255)));
            end
            default: total = $urandom_range(40, 1);
        endcase
        while (hdr_bytes.size() < total || hdr_bytes.size() == 0)
            hdr_bytes.push_back(8'($urandom_range(255)));
        if (kind == 0 && $urandom_range(7) == 0) begin
            at            = $urandom_range(hdr_bytes.size() - 1);
            hdr_bytes[at] = hdr_bytes[at] ^ 8'($urandom_range(255, 1));
        end
    endfunction

    // random lead-in, then (when formed) the footer of the returned entry
    function automatic int build_footer(input bit formed);
        int e;
        int pre;
        int at;
        ftr_bytes.delete();
        e   = pick_entry();
        pre = ($urandom_range(4) == 0) ? $urandom_range(20) : $urandom_range(3);
        repeat (pre) ftr_bytes.push_back(8'($urandom_range(255)));
        if (formed) begin
            for (int p = 0; p < gen_flen[e]; p++) ftr_bytes.push_back(gen_ftr[e][p]);
            if ($urandom_range(7) == 0 && ftr_bytes.size() != 0) begin
                at            = $urandom_range(ftr_bytes.size() - 1);
                ftr_bytes[at] = ftr_bytes[at] ^ 8'($urandom_range(255, 1));
            end
        end
        if (ftr_bytes.size() == 0) ftr_bytes.push_back(8'($urandom_range(255)));
        return e;
    endfunction

    // drains hdr_bytes/ftr_bytes into beats, optionally interleaved and with table
    // writes slipped in mid-stream
    function automatic void emit_streams(input int fe, input bit mix, input bit with_writes);
        req_beat_t b;
        bit        take_hdr;
        while (hdr_bytes.size() != 0 || ftr_bytes.size() != 0) begin
            if (hdr_bytes.size() == 0)      take_hdr = 1'b0;
            else if (ftr_bytes.size() == 0) take_hdr = 1'b1;
            else                            take_hdr = mix ? 1'($urandom_range(1)) : 1'b1;
            if (take_hdr) begin
                b       = random_beat(REQ_HDR_BYTE);
                b.value = hdr_bytes.pop_front();
                b.last  = (hdr_bytes.size() == 0);
            end else begin
                b       = random_beat(REQ_FTR_BYTE);
                b.value = ftr_bytes.pop_front();
                b.last  = (ftr_bytes.size() == 0);
                if (b.last) b.entry = 4'(fe);
            end
            queue_beat(b);
            if (with_writes && $urandom_range(99) < 4) random_write();
        end
    endfunction

    function automatic void random_action();
        int r;
        int fe;
        r = $urandom_range(99);
        if (r < 6)       random_write();
        else if (r < 10) load_lengths($urandom_range(15), pick_hlen(), pick_flen());
        else if (r < 20) load_entry($urandom_range(15));
        else if (r < 52) begin
            build_header(0);
            ftr_bytes.delete();
            emit_streams(0, 1'b0, 1'b1);
        end else if (r < 74) begin
            hdr_bytes.delete();
            fe = build_footer(1'b1);
            emit_streams(fe, 1'b0, 1'b1);
        end else if (r < 82) begin
            // header and footer streams running side by side
            build_header(0);
            fe = build_footer(1'b1);
            emit_streams(fe, 1'b1, 1'b1);
        end else if (r < 94) begin
            build_header((r < 88) ? 1 : 2);
            ftr_bytes.delete();
            emit_streams(0, 1'b0, 1'b1);
        end else begin
            hdr_bytes.delete();
            fe = build_footer(1'b0);
            emit_streams(fe, 1'b0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver: feeds pending_beats, predicts each accepted beat
    // ------------------------------------------------------------------
    int        send_idle_pct = 0;
    int        rcv_stall_pct = 0;
    req_beat_t cur_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_signature_beat(cur_beat);
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 &&
                    !(pending_beats[0].drain_first && expected_results.size() != 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_beat        = pending_beats.pop_front();
                    s_req_type      <= cur_beat.req;
                    s_entry         <= cur_beat.entry;
                    s_which_pattern <= cur_beat.which;
                    s_position      <= cur_beat.position;
                    s_byte_value    <= cur_beat.value;
                    s_header_length <= cur_beat.hlen;
                    s_footer_length <= cur_beat.flen;
                    s_last          <= cur_beat.last;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------
    int          mismatches   = 0;
    int          hold_req_cnt = 0;
    int          hold_ack_cnt = 0;
    int          hold_left    = 0;
    sig_result_t exp_r;

    function automatic void check_field(input string name, input logic [3:0] expv,
                                        input logic [3:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, kind %0d found %0d index %0d ok %0d",
                         $time, m_result_kind, m_found, m_match_index, m_footer_ok);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("result_kind", exp_r.kind,      m_result_kind);
                check_field("found",       exp_r.found,     m_found);
                check_field("match_index", exp_r.idx,       m_match_index);
                check_field("footer_ok",   exp_r.footer_ok, m_footer_ok);
            end
        end
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    task automatic write_entry_count(input int count);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 5'(count);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sig_entry_count = count;
        gen_count       = count;
    endtask

    // nothing queued, nothing offered, nothing owed, then let the pipe settle
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input int beats, input bit pressure);
        write_entry_count(count);
        send_idle_pct <= idle_pct;
        rcv_stall_pct <= stall_pct;
        // receiver holds off while the sender keeps going, so the block backs up
        if (pressure) hold_req_cnt <= hold_req_cnt + 1;
        gen_pushed = 0;
        while (gen_pushed < beats / 2) random_action();
        // sender waits here for every outstanding result
        if (pressure) gen_drain_next = 1'b1;
        while (gen_pushed < beats) random_action();
        wait_idle();
    endtask

    // table extremes, short and mismatching streams, footer edge cases
    task automatic directed_beats();
        load_byte(0, PAT_HEADER, 0, 8'h00);
        load_byte(0, PAT_HEADER, 1, 8'hFF);
        load_byte(0, PAT_HEADER, 2, 8'h5A);
        load_byte(0, PAT_HEADER, 3, 8'hA5);
        load_byte(15, PAT_FOOTER, 0, 8'hFF);
        load_byte(15, PAT_FOOTER, 1, 8'h00);
        load_byte(15, PAT_FOOTER, 31, 8'h77);     // past the footer size, dropped
        load_lengths(0, 4, 0);
        load_lengths(15, 0, 2);
        ftr_bytes.delete();
        hdr_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};  // exact match on entry 0
        emit_streams(0, 1'b0, 1'b0);
        hdr_bytes = '{8'h00, 8'hFF, 8'h5A};         // too short to match
        emit_streams(0, 1'b0, 1'b0);
        hdr_bytes = '{8'h00, 8'hFF, 8'h5A, 8'h00};  // last byte differs
        emit_streams(0, 1'b0, 1'b0);
        ftr_bytes = '{8'h11, 8'hFF, 8'h00};         // tail equals entry 15 footer
        emit_streams(15, 1'b0, 1'b0);
        ftr_bytes = '{8'h00};                       // tail shorter than the footer
        emit_streams(15, 1'b0, 1'b0);
    endtask

    initial begin
        foreach (sig_alive[e]) sig_alive[e] = 1'b1;
        sig_seen        = 0;
        sig_tail_fill   = 0;
        sig_entry_count = 0;
        gen_count       = 0;
        gen_drain_next  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        write_entry_count(ENTRIES);
        directed_beats();
        wait_idle();

        // entry_count, sender idle %, receiver stall %, beats, pressure
        run_phase(16,  0,  0, 150, 1'b0);
        run_phase(31, 73,  0, 120, 1'b0);
        run_phase( 5,  0, 73, 130, 1'b0);
        run_phase( 0, 16, 16,  90, 1'b0);
        run_phase(12,  0, 16, 200, 1'b1);
        run_phase( 1, 16, 16, 150, 1'b0);

        if (mismatches == 0)
            $display("[file_signature_matcher] OK");
        else
            $display("[file_signature_matcher] ERROR");
        $finish;
    end

    // hard stop if the run hangs waiting on a handshake or a result
    initial begin
        #(LIMIT_TIME);
        $display("[file_signature_matcher] ERROR");
        $finish;
    end

endmodule

@@ file_signature_matcher.f @@
src/fsig_pkg.sv
src/file_signature_matcher.sv
sim/tb_file_signature_matcher.sv
